/* src/coalescing_deferred_call_queue_assert.svh */
// Assertion helpers for the deferred-call queue checks.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef COALESCING_DEFERRED_CALL_QUEUE_ASSERT_SVH
`define COALESCING_DEFERRED_CALL_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDCQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDCQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/cdcq_pkg.sv */
package cdcq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 64;

   // Request kinds
   localparam logic KIND_POST = 1'b0;
   localparam logic KIND_TAKE = 1'b1;

   // Result status codes
   localparam logic [2:0] STATUS_QUEUED    = 3'd0;
   localparam logic [2:0] STATUS_MERGED    = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_DELIVERED = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [31:0] handler;
      logic [31:0] argument;
      logic        needs_lock;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        raise_soft_interrupt;
      logic [31:0] out_handler;
      logic [31:0] out_argument;
      logic        out_needs_lock;
   } rsp_type;

   // One queue slot
   typedef struct packed {
      logic        needs_lock;
      logic [31:0] argument;
      logic [31:0] handler;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAKE,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic scan;
      logic take_rd;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

/* src/coalescing_deferred_call_queue.sv */
// Coalescing deferred-call queue: a FIFO of up to QUEUE_DEPTH pending
// handler calls. A post (kind 0) is checked against every queued entry;
// a handler and argument match reports merged and keeps the queued entry's
// lock flag, otherwise the request is appended (queued, with
// raise_soft_interrupt set when the queue was empty) or dropped with status
// full. A take (kind 1) returns the oldest entry or status empty. Items are
// handled one at a time. The duplicate search reads one queued slot per
// cycle through the single read port of the slot memory, so a post with no
// match reads every queued entry before it finishes; a match ends the search
// early. A take reads only the head slot. Each item gives exactly one result
// beat, held in an output register, so the next request is accepted while a
// result still waits for the consumer; a consumer stall holds the block only
// when a new result finds the previous one still waiting.
module coalescing_deferred_call_queue
   import cdcq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   cdcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdcq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/cdcq_ctrl.sv */
module cdcq_ctrl
   import cdcq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_TAKE) ? ST_TAKE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_TAKE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_TAKE: begin
            cmd.take_rd = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* src/cdcq_dpath.sv */
module cdcq_dpath
   import cdcq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] nxt;
      nxt = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      return nxt;
   endfunction

   entry_type        mem [QUEUE_DEPTH];
   entry_type        rd_data_ff;
   req_type          req_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_slot_ff;
   logic [CNT_W-1:0] issue_cnt_ff;
   logic             rd_valid_ff;
   logic             hit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             scan_more;
   logic             match;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   entry_type        wr_data;

   // Scan and read control
   assign scan_more = (issue_cnt_ff != count_ff);
   assign match     = rd_valid_ff && (rd_data_ff.handler == req_ff.handler)
                      && (rd_data_ff.argument == req_ff.argument);
   assign rd_en     = (cmd.scan && scan_more) || cmd.take_rd;
   assign rd_addr   = cmd.take_rd ? head_ff : scan_slot_ff;

   assign sts.scan_done = match || (!scan_more && !rd_valid_ff);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_data.needs_lock = req_ff.needs_lock;
   assign wr_data.argument   = req_ff.argument;
   assign wr_data.handler    = req_ff.handler;

   // Resolve the item: queue, merge, drop, deliver or report empty
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      rsp_in   = '0;
      if (cmd.finish) begin
         if (req_ff.kind == KIND_POST) begin
            priority if (hit_ff) begin
               rsp_in.status = STATUS_MERGED;
            end else if (count_ff == FULL_CNT) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               wr_en                       = 1'b1;
               tail_in                     = next_slot(tail_ff);
               count_in                    = count_ff + 1'b1;
               rsp_in.status               = STATUS_QUEUED;
               rsp_in.raise_soft_interrupt = (count_ff == '0);
            end
         end else begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               head_in               = next_slot(head_ff);
               count_in              = count_ff - 1'b1;
               rsp_in.status         = STATUS_DELIVERED;
               rsp_in.out_handler    = rd_data_ff.handler;
               rsp_in.out_argument   = rd_data_ff.argument;
               rsp_in.out_needs_lock = rd_data_ff.needs_lock;
            end
         end
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Queue pointers, scan state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         scan_slot_ff <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            scan_slot_ff <= head_ff;
            issue_cnt_ff <= '0;
            rd_valid_ff  <= 1'b0;
            hit_ff       <= 1'b0;
         end else if (cmd.scan) begin
            if (scan_more) begin
               scan_slot_ff <= next_slot(scan_slot_ff);
               issue_cnt_ff <= issue_cnt_ff + 1'b1;
            end
            rd_valid_ff <= scan_more;
            if (match) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   // Latch the request and the result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/cdcq_checker.sv */
`include "coalescing_deferred_call_queue_assert.svh"

module cdcq_checker
   import cdcq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_waiting;
   logic req_taken;
   logic rsp_raise;
   logic rsp_queued;
   logic rsp_no_entry;
   logic rsp_payload_zero;

   // Handshake and payload views used by the checks
   assign rsp_waiting      = rsp_valid && rsp_stall;
   assign req_taken        = req_valid && !req_stall;
   assign rsp_raise        = rsp_valid && rsp_data.raise_soft_interrupt;
   assign rsp_queued       = (rsp_data.status == STATUS_QUEUED);
   assign rsp_no_entry     = rsp_valid && (rsp_data.status != STATUS_DELIVERED);
   assign rsp_payload_zero = (rsp_data.out_handler == '0) && (rsp_data.out_argument == '0)
                             && !rsp_data.out_needs_lock;

   // A stalled result beat holds
   `CDCQ_ASSERT_NEXT(a_rsp_hold, rsp_waiting, rsp_valid && $stable(rsp_data), "beat not held")

   // Block is busy right after taking a request
   `CDCQ_ASSERT_NEXT(a_busy_after_accept, req_taken, req_stall, "accepted back to back")

   // Status stays within its codes
   `CDCQ_ASSERT_NOW(a_status_range, rsp_valid, rsp_data.status <= STATUS_EMPTY, "bad status")

   // Soft interrupt only on a queued post
   `CDCQ_ASSERT_NOW(a_raise_queued, rsp_raise, rsp_queued, "raise without queueing")

   // Only a delivery carries an entry
   `CDCQ_ASSERT_NOW(a_zero_payload, rsp_no_entry, rsp_payload_zero, "payload without delivery")

endmodule

bind coalescing_deferred_call_queue cdcq_checker u_checker (.*);
